// File: rtl/prc_pkg.sv
// Shared constants, types and the arctangent table of the polar/rectangular converter.
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  // Number of CORDIC micro-rotations (8..30)
  localparam int ITERATIONS = 16;
  // Datapath width: Q16.16 plus eight guard bits plus CORDIC growth and sign
  localparam int W  = 44;
  // Angle accumulator width, degrees in Q16.16
  localparam int ZW = 27;
  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // CORDIC gain limit in Q0.30
  localparam logic [29:0] GAIN = 30'd652032874;

  localparam logic signed [ZW-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ZW-1:0] DEG360 = 27'sd23592960;

  // Command codes
  localparam logic CMD_P2R = 1'b0;
  localparam logic CMD_R2P = 1'b1;

  // Quadrant offset applied to the vectoring angle
  typedef enum logic [1:0] {
    BASE_NONE,
    BASE_POS,
    BASE_NEG
  } base_e;

  // One classified item on its way through the CORDIC back end
  typedef struct packed {
    logic                 mode;
    logic                 neg;
    logic                 zero;
    base_e                base;
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // round(atan(2^-i) in degrees * 2^16)
  function automatic logic [21:0] atan_tab(input int unsigned idx);
    logic [21:0] v;
    case (idx)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/prc_if.sv
// Handshake interfaces for the coordinate input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface prc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [30:0] radius;
  logic signed [25:0] angle_deg;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, command, radius, angle_deg, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, command, radius, angle_deg, x_coord, y_coord,
                  output ready);
endinterface

interface prc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic        [30:0] out_radius;
  logic signed [24:0] out_angle_deg;
  logic               overflow;

  modport source (output valid, out_x, out_y, out_radius, out_angle_deg, overflow,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_radius, out_angle_deg, overflow,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/prc_front.sv
// Front end: accepts coordinate pairs, reduces and folds angles, prescales the radius.
`timescale 1ns / 1ps
`default_nettype none

module prc_front import prc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prc_in_if.sink    in_i,
  output cordic_t   item_o,
  output logic      item_valid_o,
  input  wire logic full_i
);

  logic front_en;

  // Stage one registers
  logic                 f1_valid_q;
  logic                 f1_mode_q;
  logic signed [ZW-1:0] f1_ang_q, f1_ang_d;
  logic        [44:0]   f1_ph_q, f1_ph_d;
  logic        [45:0]   f1_pl_q, f1_pl_d;
  logic signed [32:0]   f1_xs_q, f1_xs_d;
  logic signed [32:0]   f1_ys_q, f1_ys_d;
  logic                 f1_zero_q, f1_zero_d;
  base_e                f1_base_q, f1_base_d;

  // Stage two registers
  logic    f2_valid_q;
  cordic_t f2_item_q, f2_item_d;

  // Advance while the last stage is empty or can be pushed
  assign front_en    = !f2_valid_q || !full_i;
  assign in_i.ready  = front_en;

  // Reduce the angle into -180..180 and split the gain product
  always_comb begin
    logic signed [ZW-1:0] a0, a1, a2;
    logic signed [32:0]   xe, ye;
    a0 = ZW'(in_i.angle_deg);
    if (a0 >= DEG360) begin
      a1 = a0 - DEG360;
    end else if (a0 <= -DEG360) begin
      a1 = a0 + DEG360;
    end else begin
      a1 = a0;
    end
    a2 = (a1 < 0) ? a1 + DEG360 : a1;
    f1_ang_d = (a2 >= DEG180) ? a2 - DEG360 : a2;

    f1_ph_d = 45'(in_i.radius[30:16]) * 45'(GAIN);
    f1_pl_d = 46'(in_i.radius[15:0]) * 46'(GAIN);

    xe = 33'(in_i.x_coord);
    ye = 33'(in_i.y_coord);
    f1_zero_d = (in_i.x_coord == 32'sd0) && (in_i.y_coord == 32'sd0);
    if (in_i.x_coord < 0) begin
      f1_xs_d   = -xe;
      f1_ys_d   = -ye;
      f1_base_d = (in_i.y_coord >= 0) ? BASE_POS : BASE_NEG;
    end else begin
      f1_xs_d   = xe;
      f1_ys_d   = ye;
      f1_base_d = BASE_NONE;
    end
  end

  // Fold the angle into -90..90 and build the initial CORDIC vector
  always_comb begin
    logic [46:0]          p;
    logic signed [ZW-1:0] a;
    f2_item_d      = '0;
    f2_item_d.mode = f1_mode_q;
    f2_item_d.zero = f1_zero_q;
    f2_item_d.base = f1_base_q;
    if (f1_mode_q == CMD_P2R) begin
      p = {2'b00, f1_ph_q} + {17'd0, f1_pl_q[45:16]} + 47'd32;
      a = f1_ang_q;
      f2_item_d.neg = 1'b0;
      if (a > DEG90) begin
        a             = a - DEG180;
        f2_item_d.neg = 1'b1;
      end else if (a < -DEG90) begin
        a             = a + DEG180;
        f2_item_d.neg = 1'b1;
      end
      f2_item_d.x = W'(p[46:6]);
      f2_item_d.y = '0;
      f2_item_d.z = a;
    end else begin
      p             = '0;
      a             = '0;
      f2_item_d.neg = 1'b0;
      f2_item_d.x   = W'(f1_xs_q) <<< 8;
      f2_item_d.y   = W'(f1_ys_q) <<< 8;
      f2_item_d.z   = a;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (front_en) begin
      f1_valid_q <= in_i.valid;
      f2_valid_q <= f1_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      f1_mode_q <= in_i.command;
      f1_ang_q  <= f1_ang_d;
      f1_ph_q   <= f1_ph_d;
      f1_pl_q   <= f1_pl_d;
      f1_xs_q   <= f1_xs_d;
      f1_ys_q   <= f1_ys_d;
      f1_zero_q <= f1_zero_d;
      f1_base_q <= f1_base_d;
      f2_item_q <= f2_item_d;
    end
  end

  assign item_o       = f2_item_q;
  assign item_valid_o = f2_valid_q;

endmodule

`default_nettype wire

// File: rtl/prc_queue.sv
// Short queue decoupling the front end from the CORDIC back end.
`timescale 1ns / 1ps
`default_nettype none

module prc_queue import prc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire cordic_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output cordic_t      data_o,
  output logic         empty_o
);

  cordic_t          mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/prc_back.sv
// Back end: unrolled CORDIC pipeline with final gain scaling, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module prc_back import prc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cordic_t item_i,
  input  wire logic    item_valid_i,
  output logic         pop_o,
  prc_out_if.source    out_o
);

  logic    back_en;
  logic    out_valid_q;
  cordic_t s0_q;
  logic    s0_valid_q;

  cordic_t stage   [ITERATIONS+1];
  logic    stage_v [ITERATIONS+1];

  // Whole pipeline moves unless the result register is held
  assign back_en = !out_valid_q || out_o.ready;
  assign pop_o   = back_en && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (back_en) begin
      s0_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) s0_q <= item_i;
  end

  assign stage[0]   = s0_q;
  assign stage_v[0] = s0_valid_q;

  // One micro-rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    cordic_t nxt_d, nxt_q;
    logic    v_q;

    always_comb begin
      logic signed [W-1:0]  cx, cy;
      logic signed [ZW-1:0] t;
      logic                 dir;
      cx    = stage[i].x;
      cy    = stage[i].y;
      t     = ZW'(atan_tab(i));
      nxt_d = stage[i];
      dir   = (stage[i].mode == CMD_R2P) ? cy[W-1] : !stage[i].z[ZW-1];
      if (dir) begin
        nxt_d.x = cx - (cy >>> i);
        nxt_d.y = cy + (cx >>> i);
        nxt_d.z = stage[i].z - t;
      end else begin
        nxt_d.x = cx + (cy >>> i);
        nxt_d.y = cy - (cx >>> i);
        nxt_d.z = stage[i].z + t;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (back_en) begin
        v_q <= stage_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (back_en) nxt_q <= nxt_d;
    end

    assign stage[i+1]   = nxt_q;
    assign stage_v[i+1] = v_q;
  end

  // Post stage one: undo the fold, clamp the angle, multiply by the gain
  logic                 p1_valid_q;
  logic                 p1_mode_q, p1_zero_q;
  logic signed [W-1:0]  p1_x_q, p1_y_q, p1_x_d, p1_y_d;
  logic        [57:0]   p1_ph_q, p1_ph_d;
  logic        [45:0]   p1_pl_q, p1_pl_d;
  logic signed [ZW-1:0] p1_ang_q, p1_ang_d;

  always_comb begin
    cordic_t              s;
    logic signed [W-1:0]  xc;
    logic signed [ZW-1:0] b, a;
    s = stage[ITERATIONS];
    if (s.neg) begin
      p1_x_d = -s.x;
      p1_y_d = -s.y;
    end else begin
      p1_x_d = s.x;
      p1_y_d = s.y;
    end
    xc      = s.x[W-1] ? '0 : s.x;
    p1_ph_d = 58'(xc[W-1:16]) * 58'(GAIN);
    p1_pl_d = 46'(xc[15:0]) * 46'(GAIN);
    case (s.base)
      BASE_POS: b = DEG180;
      BASE_NEG: b = -DEG180;
      default:  b = '0;
    endcase
    a = b + s.z;
    if (a > DEG180) begin
      p1_ang_d = DEG180;
    end else if (a < -DEG180) begin
      p1_ang_d = -DEG180;
    end else begin
      p1_ang_d = a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (back_en) begin
      p1_valid_q <= stage_v[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      p1_mode_q <= stage[ITERATIONS].mode;
      p1_zero_q <= stage[ITERATIONS].zero;
      p1_x_q    <= p1_x_d;
      p1_y_q    <= p1_y_d;
      p1_ph_q   <= p1_ph_d;
      p1_pl_q   <= p1_pl_d;
      p1_ang_q  <= p1_ang_d;
    end
  end

  // Post stage two: round, saturate and select by mode
  logic signed [31:0] res_x_d, res_y_d;
  logic        [30:0] res_rad_d;
  logic signed [24:0] res_ang_d;
  logic               res_ovf_d;

  always_comb begin
    logic signed [W-1:0] rx, ry;
    logic        [58:0]  p;
    logic        [36:0]  rad;
    rx = (p1_x_q + W'(128)) >>> 8;
    ry = (p1_y_q + W'(128)) >>> 8;
    p  = {1'b0, p1_ph_q} + {29'd0, p1_pl_q[45:16]} + (59'd1 << 21);
    rad = p[58:22];
    res_x_d   = '0;
    res_y_d   = '0;
    res_rad_d = '0;
    res_ang_d = '0;
    res_ovf_d = 1'b0;
    if (p1_mode_q == CMD_P2R) begin
      if (rx > W'(64'sd2147483647)) begin
        res_x_d = 32'sh7FFFFFFF;
      end else if (rx < -W'(64'sd2147483648)) begin
        res_x_d = 32'sh80000000;
      end else begin
        res_x_d = rx[31:0];
      end
      if (ry > W'(64'sd2147483647)) begin
        res_y_d = 32'sh7FFFFFFF;
      end else if (ry < -W'(64'sd2147483648)) begin
        res_y_d = 32'sh80000000;
      end else begin
        res_y_d = ry[31:0];
      end
    end else if (!p1_zero_q) begin
      if (rad > 37'h007FFFFFFF) begin
        res_rad_d = 31'h7FFFFFFF;
        res_ovf_d = 1'b1;
      end else begin
        res_rad_d = rad[30:0];
      end
      res_ang_d = p1_ang_q[24:0];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      out_o.out_x         <= res_x_d;
      out_o.out_y         <= res_y_d;
      out_o.out_radius    <= res_rad_d;
      out_o.out_angle_deg <= res_ang_d;
      out_o.overflow      <= res_ovf_d;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/polar_rectangular_converter.sv
// Top level of the CORDIC polar/rectangular converter.
// Converts one Q16.16 coordinate pair per transaction: command 0 rotates
// (radius, angle in degrees) into x and y, command 1 vectors (x, y) into a
// saturating radius with overflow flag and a four-quadrant angle in -180..180.
// One transaction is accepted every clock cycle unless the front end holds an
// item that the full queue cannot take. Results pass through two front stages,
// the four-entry queue, one queue read stage, one unrolled CORDIC stage per
// iteration and two scaling stages. A stalled result holds the whole back end;
// the queue keeps the front accepting until it fills.
`timescale 1ns / 1ps
`default_nettype none

module polar_rectangular_converter import prc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prc_in_if.sink    in_i,
  prc_out_if.source out_o
);

  cordic_t front_item, queue_item;
  logic    front_valid, queue_full, queue_empty, back_pop;

  prc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .full_i       (queue_full)
  );

  prc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .data_o  (queue_item),
    .empty_o (queue_empty)
  );

  prc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .item_valid_i (!queue_empty),
    .pop_o        (back_pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: tb/prc_tb_checker.sv
// Result checker for the polar/rectangular converter: predicts and compares each transaction.
`timescale 1ns / 1ps
`default_nettype none

module prc_tb_checker import prc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prc_in_if.sink    in_i,
  prc_out_if.sink   out_o,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_o
);

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] crad;
    logic signed [24:0] cang;
    logic               cov;
  } conv_res_t;

  conv_res_t expected_q[$];
  int        mismatches;
  int        seen;

  // arctangent table in degrees, Q16.16
  function automatic longint atan_step(input int i);
    longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
                      2, 1};
    if (i < 23) return t[i];
    return 0;
  endfunction

  // arithmetic shift right rounding towards minus infinity
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  // round(v * gain / 2^s)
  function automatic longint scale_gain(input longint unsigned v, input int s);
    longint unsigned p;
    p = (v >> 16) * 64'd652032874 + (((v & 64'hFFFF) * 64'd652032874) >> 16);
    return longint'((p + (64'd1 << (s - 17))) >> (s - 16));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic conv_res_t convert(input logic cmd, input logic [30:0] r,
                                        input logic signed [25:0] a_in,
                                        input logic signed [31:0] xi,
                                        input logic signed [31:0] yi);
    conv_res_t res;
    longint    x, y, z, nx, a, xs, ys, base, ang;
    longint unsigned rad;
    logic      flip;
    res = '{0, 0, 0, 0, 0};
    flip = 1'b0;
    if (cmd == CMD_P2R) begin
      a = a_in;
      a = a % 23592960;
      if (a < 0) a += 23592960;
      if (a >= 11796480) a -= 23592960;
      if (a > 5898240) begin
        a -= 11796480; flip = 1'b1;
      end else if (a < -5898240) begin
        a += 11796480; flip = 1'b1;
      end
      x = scale_gain(longint'(r), 22);
      y = 0;
      z = a;
      for (int i = 0; i < ITERATIONS && i < 30; i++) begin
        if (z >= 0) begin
          nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atan_step(i);
        end else begin
          nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atan_step(i);
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      res.cx = 32'(clamp32(floor_shift(x + 128, 8)));
      res.cy = 32'(clamp32(floor_shift(y + 128, 8)));
    end else begin
      xs = xi;
      ys = yi;
      if (xs == 0 && ys == 0) return res;
      base = 0;
      if (xs < 0) begin
        base = (ys >= 0) ? 11796480 : -11796480;
        xs = -xs; ys = -ys;
      end
      x = xs * 256;
      y = ys * 256;
      z = 0;
      for (int i = 0; i < ITERATIONS && i < 30; i++) begin
        if (y >= 0) begin
          nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atan_step(i);
        end else begin
          nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atan_step(i);
        end
        x = nx;
      end
      if (x < 0) x = 0;
      rad = longint'(scale_gain(longint'(x), 38));
      if (rad > 64'h7FFFFFFF) begin
        rad = 64'h7FFFFFFF; res.cov = 1'b1;
      end
      ang = base + z;
      if (ang > 11796480) ang = 11796480;
      if (ang < -11796480) ang = -11796480;
      res.crad = 31'(rad);
      res.cang = 25'(ang);
    end
    return res;
  endfunction

  // queue expectations on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    conv_res_t want;
    if (!rst_ni) begin
      mismatches <= 0;
      seen <= 0;
    end else begin
      if (in_i.valid && in_i.ready)
        expected_q.push_back(convert(in_i.command, in_i.radius, in_i.angle_deg,
                                     in_i.x_coord, in_i.y_coord));
      if (out_o.valid && out_o.ready) begin
        seen <= seen + 1;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("ERROR: unexpected result transaction");
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_o.out_x !== want.cx || out_o.out_y !== want.cy ||
              out_o.out_radius !== want.crad || out_o.out_angle_deg !== want.cang ||
              out_o.overflow !== want.cov) begin
            if (mismatches < 10)
              $display("ERROR: exp x=%0d y=%0d r=%0d a=%0d ov=%0b got x=%0d y=%0d r=%0d a=%0d ov=%0b",
                       want.cx, want.cy, want.crad, want.cang, want.cov, out_o.out_x,
                       out_o.out_y, out_o.out_radius, out_o.out_angle_deg, out_o.overflow);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = expected_q.size();
  assign results_o    = seen;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Top of the converter testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import prc_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000;
  localparam int RANDOM_ITEMS   = 1100;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   results;
  int   idle_cycles;
  int   sent;
  bit   long_hold;

  prc_in_if  conv_in ();
  prc_out_if conv_out ();

  polar_rectangular_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (conv_in.sink),
    .out_o  (conv_out.source)
  );

  prc_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (conv_in.sink),
    .out_o        (conv_out.sink),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // place one transaction on the input and hold until accepted
  task automatic offer(input logic cmd, input logic [30:0] r, input logic signed [25:0] a,
                       input logic signed [31:0] xv, input logic signed [31:0] yv);
    conv_in.valid     <= 1'b1;
    conv_in.command   <= cmd;
    conv_in.radius    <= r;
    conv_in.angle_deg <= a;
    conv_in.x_coord   <= xv;
    conv_in.y_coord   <= yv;
    do @(posedge clk_i); while (!conv_in.ready);
    sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(1, 6);
    conv_in.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 2000)) - 1000;
      3: return 32'($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      default: return 32'($urandom());
    endcase
  endfunction

  // receiver stall pattern, with one long hold-off while the sender keeps going
  initial begin
    int phase;
    conv_out.ready = 1'b0;
    long_hold = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase++;
      if (sent > 300 && !long_hold) begin
        long_hold = 1'b1;
        conv_out.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      if (phase % 200 < 60)
        conv_out.ready <= 1'b1;
      else
        conv_out.ready <= (phase % 7 != 0) && ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog: count cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni)
      idle_cycles <= 0;
    else if ((conv_in.valid && conv_in.ready) || (conv_out.valid && conv_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    int settle;
    logic signed [25:0] ang;
    sent = 0;
    rst_ni = 1'b0;
    conv_in.valid = 1'b0;
    conv_in.command = CMD_P2R;
    conv_in.radius = '0;
    conv_in.angle_deg = '0;
    conv_in.x_coord = '0;
    conv_in.y_coord = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, folding, origin, each quadrant
    offer(CMD_P2R, '0, '0, '0, '0);
    offer(CMD_P2R, 31'h7FFFFFFF, 26'sd0, '0, '0);
    offer(CMD_P2R, 31'h7FFFFFFF, 26'sd23592960, '0, '0);
    offer(CMD_P2R, 31'h7FFFFFFF, -26'sd23592960, '0, '0);
    offer(CMD_P2R, 31'h00010000, 26'sd5898240, '0, '0);
    offer(CMD_P2R, 31'h00010000, 26'sd11796480, '0, '0);
    offer(CMD_P2R, 31'h00010000, -26'sd11796480, '0, '0);
    offer(CMD_P2R, 31'h7FFFFFFF, 26'sd8847360, '0, '0);
    offer(CMD_P2R, 31'h12345678, -26'sd33554432, 32'sh7FFFFFFF, 32'sh80000000);
    offer(CMD_P2R, 31'h12345678, 26'sd33554431, '0, '0);
    offer(CMD_R2P, '0, '0, 32'sd0, 32'sd0);
    offer(CMD_R2P, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    offer(CMD_R2P, '0, '0, 32'sh80000000, 32'sh80000000);
    offer(CMD_R2P, '0, '0, 32'sh80000000, 32'sd0);
    offer(CMD_R2P, '0, '0, -32'sd65536, -32'sd1);
    offer(CMD_R2P, '0, '0, 32'sd65536, 32'sd0);
    offer(CMD_R2P, '0, '0, 32'sd0, -32'sd65536);
    offer(CMD_R2P, '0, '0, 32'sd0, 32'sd65536);
    offer(CMD_R2P, '0, '0, 32'sh7FFFFFFF, 32'sh80000000);
    offer(CMD_R2P, 31'h7FFFFFFF, 26'sh3FFFFFF, -32'sd1, 32'sd0);

    // random bursts with gaps between them
    while (sent < RANDOM_ITEMS + 20) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        ang = ($urandom_range(0, 7) == 0) ? 26'($urandom())
                                          : 26'($urandom_range(0, 47185920)) - 26'sd23592960;
        offer(logic'($urandom_range(0, 1)), 31'($urandom() >> $urandom_range(0, 31)), ang,
              pick_coord(), pick_coord());
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    conv_in.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    settle = ITERATIONS + 20;
    repeat (settle) @(posedge clk_i);

    $display("Sent %0d conversions in both directions, %0d results checked,", sent, results);
    $display("including range extremes, angle folding, origin and a long output stall.");
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/prc_pkg.sv
rtl/prc_if.sv
rtl/prc_front.sv
rtl/prc_queue.sv
rtl/prc_back.sv
rtl/polar_rectangular_converter.sv
tb/prc_tb_checker.sv
tb/testbench.sv
